### hdl/rrs_pkg.sv
package rrs_pkg;

    // request codes
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_MANUAL   = 3'd1;
    localparam logic [2:0] REQ_TOGGLE   = 3'd2;
    localparam logic [2:0] REQ_NOOP     = 3'd3;
    localparam logic [2:0] REQ_RST_CNT  = 3'd4;

    // reject reasons
    localparam logic [1:0] REJ_NONE     = 2'd0;
    localparam logic [1:0] REJ_NO_SITE  = 2'd1;
    localparam logic [1:0] REJ_BUSY     = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDSHAKE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_FULL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_FULL = 3'd4;

    localparam int unsigned CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [7:0]  RST_HANDSHAKE = 8'd3;
    localparam logic [7:0]  RST_MATE      = 8'd5;
    localparam logic [7:0]  RST_TIMEOUT   = 8'd120;
    localparam logic [15:0] RST_PROP_FULL = 16'd27450;
    localparam logic [9:0]  RST_BATT_FULL = 10'd950;

    typedef struct packed {
        logic [7:0]  handshake_ticks;
        logic [7:0]  mate_ticks;
        logic [7:0]  timeout_ticks;
        logic [15:0] prop_full_level;
        logic [9:0]  batt_full_level;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        phase_valid;
        logic        on_surface_or_docked;
        logic        node_has_refuel;
        logic        prop_valid;
        logic [15:0] prop_total_mass;
        logic        eps_valid;
        logic [9:0]  batt_charge;
    } t_req;

    typedef struct packed {
        logic [2:0]  reported_state;
        logic        prop_refuel_pulse;
        logic [1:0]  reject_reason;
        logic        auto_enabled;
        logic [15:0] accepted_count;
        logic [15:0] error_count;
    } t_res;

endpackage

### hdl/rrs_cfg_regs.sv
module rrs_cfg_regs
    import rrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.handshake_ticks <= RST_HANDSHAKE;
            r_cfg.mate_ticks      <= RST_MATE;
            r_cfg.timeout_ticks   <= RST_TIMEOUT;
            r_cfg.prop_full_level <= RST_PROP_FULL;
            r_cfg.batt_full_level <= RST_BATT_FULL;
        end else if (i_wr_en) begin
            unique case (i_index)
                CFG_HANDSHAKE: r_cfg.handshake_ticks <= i_data[7:0];
                CFG_MATE:      r_cfg.mate_ticks      <= i_data[7:0];
                CFG_TIMEOUT:   r_cfg.timeout_ticks   <= i_data[7:0];
                CFG_PROP_FULL: r_cfg.prop_full_level <= i_data[15:0];
                CFG_BATT_FULL: r_cfg.batt_full_level <= i_data[9:0];
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/rrs_step.sv
module rrs_step
    import rrs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_req i_req,
    input  t_cfg i_cfg,
    output t_res o_res
);

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_HANDSHAKE = 3'd1,
        ST_MATE      = 3'd2,
        ST_TRANSFER  = 3'd3,
        ST_RECHARGE  = 3'd4,
        ST_COMPLETE  = 3'd5
    } t_seq_state;

    t_seq_state  r_state, n_state;
    logic [7:0]  r_timer, n_timer;
    logic        r_capable, n_capable;
    logic        r_auto, n_auto;
    logic [15:0] r_good, n_good;
    logic [15:0] r_bad, n_bad;

    logic        w_pulse;
    logic [1:0]  w_reason;
    logic [8:0]  w_inc;
    logic [8:0]  w_base;
    logic        w_prop_full;
    logic        w_batt_full;

    assign w_inc       = {1'b0, r_timer} + 9'd1;
    assign w_prop_full = i_req.prop_valid && (i_req.prop_total_mass >= i_cfg.prop_full_level);
    assign w_batt_full = i_req.eps_valid && (i_req.batt_charge >= i_cfg.batt_full_level);

    always_comb begin
        n_state   = r_state;
        n_timer   = r_timer;
        n_capable = r_capable;
        n_auto    = r_auto;
        n_good    = r_good;
        n_bad     = r_bad;
        w_pulse   = 1'b0;
        w_reason  = REJ_NONE;
        w_base    = w_inc;
        unique case (i_req.req_type)
            REQ_TICK: begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (i_req.phase_valid && i_req.on_surface_or_docked) begin
                            n_capable = r_capable || i_req.node_has_refuel;
                            if (n_capable && r_auto) begin
                                n_state = ST_HANDSHAKE;
                                n_timer = 8'd0;
                            end
                        end
                    end
                    ST_HANDSHAKE: begin
                        n_timer = w_inc[7:0];
                        if (w_inc >= {1'b0, i_cfg.handshake_ticks}) begin
                            n_state = ST_MATE;
                            n_timer = 8'd0;
                        end
                    end
                    ST_MATE: begin
                        n_timer = w_inc[7:0];
                        if (w_inc >= {1'b0, i_cfg.mate_ticks}) begin
                            n_state = ST_TRANSFER;
                            n_timer = 8'd0;
                            w_pulse = 1'b1;
                        end
                    end
                    ST_TRANSFER: begin
                        // level reached restarts the timer before the timeout check
                        if (w_prop_full) begin
                            n_state = ST_RECHARGE;
                            w_base  = 9'd1;
                        end
                        n_timer = w_base[7:0];
                        if (w_base > {1'b0, i_cfg.timeout_ticks}) begin
                            n_state = ST_IDLE;
                        end
                    end
                    ST_RECHARGE: begin
                        if (w_batt_full) begin
                            n_state = ST_COMPLETE;
                            w_base  = 9'd1;
                        end
                        n_timer = w_base[7:0];
                        if (w_base > {1'b0, i_cfg.timeout_ticks}) begin
                            n_state = ST_COMPLETE;
                            n_timer = 8'd0;
                        end
                    end
                    ST_COMPLETE: begin
                        if (i_req.phase_valid && !i_req.on_surface_or_docked) begin
                            n_state   = ST_IDLE;
                            n_capable = 1'b0;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            REQ_MANUAL: begin
                if (r_state == ST_IDLE && r_capable) begin
                    n_state = ST_HANDSHAKE;
                    n_timer = 8'd0;
                    n_good  = r_good + 16'd1;
                end else begin
                    n_bad    = r_bad + 16'd1;
                    w_reason = r_capable ? REJ_BUSY : REJ_NO_SITE;
                end
            end
            REQ_TOGGLE: begin
                n_auto = !r_auto;
                n_good = r_good + 16'd1;
            end
            REQ_NOOP: begin
                n_good = r_good + 16'd1;
            end
            REQ_RST_CNT: begin
                n_good = 16'd0;
                n_bad  = 16'd0;
            end
            default: begin
                n_bad = r_bad + 16'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_timer   <= 8'd0;
            r_capable <= 1'b0;
            r_auto    <= 1'b1;
            r_good    <= 16'd0;
            r_bad     <= 16'd0;
        end else if (i_fire) begin
            r_state   <= n_state;
            r_timer   <= n_timer;
            r_capable <= n_capable;
            r_auto    <= n_auto;
            r_good    <= n_good;
            r_bad     <= n_bad;
        end
    end

    assign o_res.reported_state    = r_state;
    assign o_res.prop_refuel_pulse = w_pulse;
    assign o_res.reject_reason     = w_reason;
    assign o_res.auto_enabled      = n_auto;
    assign o_res.accepted_count    = n_good;
    assign o_res.error_count       = n_bad;

    a_pulse_enters_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_pulse |=> r_state == ST_TRANSFER && r_timer == 8'd0)
        else $error("refuel pulse without entry to transfer");

    a_reason_only_manual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_reason != REJ_NONE |->
            i_req.req_type == REQ_MANUAL && (r_state != ST_IDLE || !r_capable))
        else $error("reject reason on an item that is not a rejected start");

    a_counter_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_req.req_type == REQ_RST_CNT |=> r_good == 16'd0 && r_bad == 16'd0)
        else $error("counters not cleared");

    a_leave_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_state == ST_COMPLETE && n_state == ST_IDLE |=> !r_capable)
        else $error("site flag kept after departure");

endmodule

### hdl/refuel_recharge_sequencer_top.sv
// refuel and recharge sequencer
//
// input channel: one beat per tick or command (i_req_type and telemetry
//   fields), i_in_valid with o_in_stall; a beat is taken when valid is high
//   and stall is low
// output channel: one result beat per input beat, in order, o_out_valid with
//   i_out_stall from the receiver
// config channel: i_cfg_valid / o_cfg_ready, index 0..4 selects a timing or
//   level register, other indexes are ignored; o_cfg_ready is always high
// path: an input beat passes through the input register, then the step
//   logic feeding the result register
// throughput: one beat per cycle if not stalled; the sequencer state updates
//   in the single step stage, so each beat sees the state its predecessor left
// stall: a held result keeps the output register; the input register then
//   fills and o_in_stall rises until the receiver takes the result
// reset: synchronous active-low i_rst_n empties both registers, returns the
//   sequencer to idle with auto-start on, clears counters and loads the
//   default timing and level registers
module refuel_recharge_sequencer_top
    import rrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input beat
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_req_type,
    input  logic                  i_phase_valid,
    input  logic                  i_on_surface_or_docked,
    input  logic                  i_node_has_refuel,
    input  logic                  i_prop_valid,
    input  logic [15:0]           i_prop_total_mass,
    input  logic                  i_eps_valid,
    input  logic [9:0]            i_batt_charge,
    // result beat
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_reported_state,
    output logic                  o_prop_refuel_pulse,
    output logic [1:0]            o_reject_reason,
    output logic                  o_auto_enabled,
    output logic [15:0]           o_accepted_count,
    output logic [15:0]           o_error_count
);

    t_cfg w_cfg;
    t_req r_in;
    t_res w_res;
    t_res r_out;
    logic r_in_valid;
    logic r_out_valid;
    logic w_adv;        // input register moves through the step into the result register

    // config writes are always taken at once
    assign o_cfg_ready = 1'b1;

    rrs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // advance when the result register is empty or is being drained
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in.req_type             <= i_req_type;
            r_in.phase_valid          <= i_phase_valid;
            r_in.on_surface_or_docked <= i_on_surface_or_docked;
            r_in.node_has_refuel      <= i_node_has_refuel;
            r_in.prop_valid           <= i_prop_valid;
            r_in.prop_total_mass      <= i_prop_total_mass;
            r_in.eps_valid            <= i_eps_valid;
            r_in.batt_charge          <= i_batt_charge;
        end
    end

    // sequencer state and the step logic, committed only on advance
    rrs_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_req   (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_reported_state    = r_out.reported_state;
    assign o_prop_refuel_pulse = r_out.prop_refuel_pulse;
    assign o_reject_reason     = r_out.reject_reason;
    assign o_auto_enabled      = r_out.auto_enabled;
    assign o_accepted_count    = r_out.accepted_count;
    assign o_error_count       = r_out.error_count;

endmodule
